FILE: sv/cmc_pkg.sv
// Shared types and codes for the cooling mode controller.
`default_nettype none

package cmc_pkg;

    localparam int TEMP_W = 12;
    localparam int TICK_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_ACTIVE = 2'd1,
        MODE_ERROR  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CAUSE_NONE        = 3'd0,
        CAUSE_FAULT       = 3'd1,
        CAUSE_AUTO_ON     = 3'd2,
        CAUSE_AUTO_OFF    = 3'd3,
        CAUSE_LONG_PRESS  = 3'd4,
        CAUSE_SHORT_PRESS = 3'd5,
        CAUSE_CMD_ERROR   = 3'd6,
        CAUSE_CMD_RESET   = 3'd7
    } cause_t;

    localparam logic [1:0] CMD_ERROR = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT_HIGH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT_LOW  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_HALF    = 3'd4;

    localparam logic [TEMP_W-1:0] SETPOINT_HIGH_RST = 12'd250;
    localparam logic [TEMP_W-1:0] SETPOINT_LOW_RST  = 12'd200;
    localparam logic [TEMP_W-1:0] TEMP_HOLD_RST     = 12'd210;
    localparam logic [TICK_W-1:0] LONG_PRESS_RST    = 16'd1000;
    localparam logic [TICK_W-1:0] DEBOUNCE_RST      = 16'd50;
    localparam logic [TICK_W-1:0] BLINK_HALF_RST    = 16'd500;

endpackage

`default_nettype wire

FILE: sv/cooling_mode_controller.sv
// Cooling mode controller: button, command and sample rules with LED drive.
// Path: an accepted input beat passes the input register and then the result
// register; it waits while an earlier result waits on out_stall.
// Throughput: one tick beat per clock cycle while out_stall holds no result;
// one pass of compare and counter logic lies between the two registers.
// Reset: mode off, button released, counters clear, held temperature 21.0,
// configuration registers at their defaults, both pipeline stages empty.
`default_nettype none

module cooling_mode_controller #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire                               button_level,
    input  wire  [1:0]                        command,
    input  wire                               sample_strobe,
    input  wire                               sample_ok,
    input  wire  signed [cmc_pkg::TEMP_W-1:0] sample_temp,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [1:0]                        mode,
    output logic                              green_led,
    output logic                              red_led,
    output logic                              sensor_fault,
    output logic signed [cmc_pkg::TEMP_W-1:0] held_temp,
    output logic [2:0]                        cause,
    input  wire                               cfg_write,
    input  wire  [cmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire  [cmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CMP_W = (COUNT_WIDTH > cmc_pkg::TICK_W) ? COUNT_WIDTH : cmc_pkg::TICK_W;

    // configuration
    logic signed [cmc_pkg::TEMP_W-1:0] sp_high_reg;
    logic signed [cmc_pkg::TEMP_W-1:0] sp_low_reg;
    logic [cmc_pkg::TICK_W-1:0]        long_press_reg;
    logic [cmc_pkg::TICK_W-1:0]        debounce_reg;
    logic [cmc_pkg::TICK_W-1:0]        blink_half_reg;

    // input stage
    logic                              s1_valid_reg;
    logic                              s1_level_reg;
    logic [1:0]                        s1_cmd_reg;
    logic                              s1_strobe_reg;
    logic                              s1_ok_reg;
    logic signed [cmc_pkg::TEMP_W-1:0] s1_temp_reg;

    // controller state
    cmc_pkg::mode_t                    mode_reg;
    cmc_pkg::mode_t                    mode_next;
    logic                              btn_prev_reg;
    logic [COUNT_WIDTH-1:0]            press_reg;
    logic [COUNT_WIDTH-1:0]            press_next;
    logic [COUNT_WIDTH-1:0]            blink_reg;
    logic [COUNT_WIDTH-1:0]            blink_next;
    logic                              green_state_reg;
    logic                              green_state_next;
    logic signed [cmc_pkg::TEMP_W-1:0] temp_hold_reg;
    logic signed [cmc_pkg::TEMP_W-1:0] temp_hold_next;
    logic                              fault_reg;
    logic                              fault_next;
    cmc_pkg::cause_t                   cause_next;
    logic                              green_next;
    logic                              red_next;

    // result register
    logic                              out_valid_reg;
    logic [1:0]                        mode_out_reg;
    logic                              green_out_reg;
    logic                              red_out_reg;
    logic                              fault_out_reg;
    logic signed [cmc_pkg::TEMP_W-1:0] temp_out_reg;
    logic [2:0]                        cause_out_reg;

    logic in_take;
    logic advance;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_high_reg    <= cmc_pkg::SETPOINT_HIGH_RST;
            sp_low_reg     <= cmc_pkg::SETPOINT_LOW_RST;
            long_press_reg <= cmc_pkg::LONG_PRESS_RST;
            debounce_reg   <= cmc_pkg::DEBOUNCE_RST;
            blink_half_reg <= cmc_pkg::BLINK_HALF_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cmc_pkg::REG_SETPOINT_HIGH: sp_high_reg    <= cfg_data[cmc_pkg::TEMP_W-1:0];
                cmc_pkg::REG_SETPOINT_LOW:  sp_low_reg     <= cfg_data[cmc_pkg::TEMP_W-1:0];
                cmc_pkg::REG_LONG_PRESS:    long_press_reg <= cfg_data[cmc_pkg::TICK_W-1:0];
                cmc_pkg::REG_DEBOUNCE:      debounce_reg   <= cfg_data[cmc_pkg::TICK_W-1:0];
                cmc_pkg::REG_BLINK_HALF:    blink_half_reg <= cfg_data[cmc_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_level_reg  <= button_level;
            s1_cmd_reg    <= command;
            s1_strobe_reg <= sample_strobe;
            s1_ok_reg     <= sample_ok;
            s1_temp_reg   <= sample_temp;
        end
    end

    always_comb
    begin
        logic [CMP_W-1:0] blink_cmp;

        mode_next        = mode_reg;
        cause_next       = cmc_pkg::CAUSE_NONE;
        press_next       = press_reg;
        blink_next       = blink_reg;
        green_state_next = green_state_reg;
        temp_hold_next   = temp_hold_reg;
        fault_next       = fault_reg;
        green_next       = 1'b0;
        red_next         = 1'b0;

        // button
        if (!s1_level_reg && btn_prev_reg)
        begin
            press_next = '0;
        end
        else
        begin
            if (!btn_prev_reg && (press_reg != '1))
            begin
                press_next = press_reg + 1'b1;
            end
            if (s1_level_reg && !btn_prev_reg && (mode_reg != cmc_pkg::MODE_ERROR))
            begin
                if (CMP_W'(press_next) >= CMP_W'(long_press_reg))
                begin
                    mode_next  = cmc_pkg::MODE_OFF;
                    cause_next = cmc_pkg::CAUSE_LONG_PRESS;
                end
                else if (CMP_W'(press_next) >= CMP_W'(debounce_reg))
                begin
                    mode_next  = cmc_pkg::MODE_ACTIVE;
                    cause_next = cmc_pkg::CAUSE_SHORT_PRESS;
                end
            end
        end

        // command
        if (s1_cmd_reg == cmc_pkg::CMD_ERROR)
        begin
            mode_next  = cmc_pkg::MODE_ERROR;
            cause_next = cmc_pkg::CAUSE_CMD_ERROR;
        end
        else if (s1_cmd_reg == cmc_pkg::CMD_RESET)
        begin
            mode_next  = cmc_pkg::MODE_OFF;
            cause_next = cmc_pkg::CAUSE_CMD_RESET;
        end

        // sample
        if (s1_strobe_reg)
        begin
            if (!s1_ok_reg)
            begin
                fault_next = 1'b1;
                if (mode_next != cmc_pkg::MODE_ERROR)
                begin
                    mode_next  = cmc_pkg::MODE_ERROR;
                    cause_next = cmc_pkg::CAUSE_FAULT;
                end
            end
            else
            begin
                fault_next     = 1'b0;
                temp_hold_next = s1_temp_reg;
                if (mode_next != cmc_pkg::MODE_ERROR)
                begin
                    if ((s1_temp_reg >= sp_high_reg) && (mode_next != cmc_pkg::MODE_ACTIVE))
                    begin
                        mode_next  = cmc_pkg::MODE_ACTIVE;
                        cause_next = cmc_pkg::CAUSE_AUTO_ON;
                    end
                    else if ((s1_temp_reg <= sp_low_reg) && (mode_next != cmc_pkg::MODE_OFF))
                    begin
                        mode_next  = cmc_pkg::MODE_OFF;
                        cause_next = cmc_pkg::CAUSE_AUTO_OFF;
                    end
                end
            end
        end

        // LEDs
        if (blink_reg != '1)
        begin
            blink_next = blink_reg + 1'b1;
        end
        blink_cmp = CMP_W'(blink_next);
        case (mode_next)
            cmc_pkg::MODE_OFF:
            begin
                green_state_next = 1'b1;
                green_next       = 1'b1;
            end
            cmc_pkg::MODE_ACTIVE:
            begin
                if (blink_cmp >= CMP_W'(blink_half_reg))
                begin
                    blink_next       = '0;
                    green_state_next = !green_state_reg;
                end
                green_next = green_state_next;
            end
            default:
            begin
                green_state_next = 1'b0;
                red_next         = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= cmc_pkg::MODE_OFF;
            btn_prev_reg    <= 1'b1;
            press_reg       <= '0;
            blink_reg       <= '0;
            green_state_reg <= 1'b0;
            temp_hold_reg   <= cmc_pkg::TEMP_HOLD_RST;
            fault_reg       <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            btn_prev_reg    <= s1_level_reg;
            press_reg       <= press_next;
            blink_reg       <= blink_next;
            green_state_reg <= green_state_next;
            temp_hold_reg   <= temp_hold_next;
            fault_reg       <= fault_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mode_out_reg  <= mode_next;
            green_out_reg <= green_next;
            red_out_reg   <= red_next;
            fault_out_reg <= fault_next;
            temp_out_reg  <= temp_hold_next;
            cause_out_reg <= cause_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mode         = mode_out_reg;
    assign green_led    = green_out_reg;
    assign red_led      = red_out_reg;
    assign sensor_fault = fault_out_reg;
    assign held_temp    = temp_out_reg;
    assign cause        = cause_out_reg;

endmodule

`default_nettype wire

FILE: bench/cmc_checker.sv
// Tick-by-tick predictor and result scoreboard for the cooling mode controller.
module cmc_checker
    import cmc_pkg::*;
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    input  wire                      in_stall,
    input  wire                      button_level,
    input  wire  [1:0]               command,
    input  wire                      sample_strobe,
    input  wire                      sample_ok,
    input  wire  signed [TEMP_W-1:0] sample_temp,
    input  wire                      out_valid,
    input  wire                      out_stall,
    input  wire  [1:0]               mode,
    input  wire                      green_led,
    input  wire                      red_led,
    input  wire                      sensor_fault,
    input  wire  signed [TEMP_W-1:0] held_temp,
    input  wire  [2:0]               cause,
    input  wire                      cfg_write,
    input  wire  [CFG_INDEX_W-1:0]   cfg_index,
    input  wire  [CFG_DATA_W-1:0]    cfg_data,
    output int                       fail_count,
    output int                       pending_count,
    output int                       checked_count,
    output logic [7:0]               causes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        mode_t                    mode;
        logic                     green;
        logic                     red;
        logic                     fault;
        logic signed [TEMP_W-1:0] temp;
        cause_t                   cause;
    } tick_result_t;

    logic signed [TEMP_W-1:0] sp_high;
    logic signed [TEMP_W-1:0] sp_low;
    logic [TICK_W-1:0]        long_ticks;
    logic [TICK_W-1:0]        debounce;
    logic [TICK_W-1:0]        blink_half;

    mode_t                    cur_mode;
    logic                     btn_prev;
    logic [TICK_W-1:0]        press_len;
    logic [TICK_W-1:0]        blink_len;
    logic                     green_st;
    logic signed [TEMP_W-1:0] temp_hold;
    logic                     fault_st;

    tick_result_t             expected_ticks[$];

    function automatic logic [TICK_W-1:0] bump(input logic [TICK_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    task automatic advance_tick(
        input  logic                     lvl,
        input  logic [1:0]               cmd,
        input  logic                     strobe,
        input  logic                     ok,
        input  logic signed [TEMP_W-1:0] temp,
        output tick_result_t             r
    );
        cause_t why;
        logic   green;
        logic   red;
        why = CAUSE_NONE;
        green = 1'b0;
        red = 1'b0;

        if (!lvl && btn_prev)
        begin
            press_len = '0;
        end
        else
        begin
            if (!btn_prev)
                press_len = bump(press_len);
            if (lvl && !btn_prev && cur_mode != MODE_ERROR)
            begin
                if (press_len >= long_ticks)
                begin
                    cur_mode = MODE_OFF;
                    why = CAUSE_LONG_PRESS;
                end
                else if (press_len >= debounce)
                begin
                    cur_mode = MODE_ACTIVE;
                    why = CAUSE_SHORT_PRESS;
                end
            end
        end
        btn_prev = lvl;

        if (cmd == CMD_ERROR)
        begin
            cur_mode = MODE_ERROR;
            why = CAUSE_CMD_ERROR;
        end
        else if (cmd == CMD_RESET)
        begin
            cur_mode = MODE_OFF;
            why = CAUSE_CMD_RESET;
        end

        if (strobe)
        begin
            if (!ok)
            begin
                fault_st = 1'b1;
                if (cur_mode != MODE_ERROR)
                begin
                    cur_mode = MODE_ERROR;
                    why = CAUSE_FAULT;
                end
            end
            else
            begin
                fault_st = 1'b0;
                temp_hold = temp;
                if (cur_mode != MODE_ERROR)
                begin
                    if (temp >= sp_high && cur_mode != MODE_ACTIVE)
                    begin
                        cur_mode = MODE_ACTIVE;
                        why = CAUSE_AUTO_ON;
                    end
                    else if (temp <= sp_low && cur_mode != MODE_OFF)
                    begin
                        cur_mode = MODE_OFF;
                        why = CAUSE_AUTO_OFF;
                    end
                end
            end
        end

        blink_len = bump(blink_len);
        case (cur_mode)
            MODE_OFF:
            begin
                green_st = 1'b1;
                green = 1'b1;
            end
            MODE_ACTIVE:
            begin
                if (blink_len >= blink_half)
                begin
                    blink_len = '0;
                    green_st = ~green_st;
                end
                green = green_st;
            end
            default:
            begin
                green_st = 1'b0;
                red = 1'b1;
            end
        endcase

        r.mode = cur_mode;
        r.green = green;
        r.red = red;
        r.fault = fault_st;
        r.temp = temp_hold;
        r.cause = why;
    endtask

    task automatic flag_field(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_result_t fresh;
        tick_result_t want;
        if (!rst_n)
        begin
            sp_high = SETPOINT_HIGH_RST;
            sp_low = SETPOINT_LOW_RST;
            long_ticks = LONG_PRESS_RST;
            debounce = DEBOUNCE_RST;
            blink_half = BLINK_HALF_RST;
            cur_mode = MODE_OFF;
            btn_prev = 1'b1;
            press_len = '0;
            blink_len = '0;
            green_st = 1'b0;
            temp_hold = TEMP_HOLD_RST;
            fault_st = 1'b0;
            expected_ticks.delete();
            fail_count = 0;
            pending_count = 0;
            checked_count = 0;
            causes_seen = '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SETPOINT_HIGH: sp_high = cfg_data[TEMP_W-1:0];
                    REG_SETPOINT_LOW:  sp_low = cfg_data[TEMP_W-1:0];
                    REG_LONG_PRESS:    long_ticks = cfg_data[TICK_W-1:0];
                    REG_DEBOUNCE:      debounce = cfg_data[TICK_W-1:0];
                    REG_BLINK_HALF:    blink_half = cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                advance_tick(button_level, command, sample_strobe, sample_ok, sample_temp,
                             fresh);
                expected_ticks.push_back(fresh);
            end

            if (out_valid && !out_stall)
            begin
                if (expected_ticks.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result beat with no tick outstanding, mode %0d cause %0d",
                                 $time, mode, cause);
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    checked_count++;
                    causes_seen[want.cause] = 1'b1;
                    if (mode !== want.mode)
                        flag_field("mode", int'(want.mode), int'(mode));
                    if (green_led !== want.green)
                        flag_field("green_led", int'(want.green), int'(green_led));
                    if (red_led !== want.red)
                        flag_field("red_led", int'(want.red), int'(red_led));
                    if (sensor_fault !== want.fault)
                        flag_field("sensor_fault", int'(want.fault), int'(sensor_fault));
                    if (held_temp !== want.temp)
                        flag_field("held_temp", int'(want.temp), int'(held_temp));
                    if (cause !== want.cause)
                        flag_field("cause", int'(want.cause), int'(cause));
                end
            end
            pending_count = expected_ticks.size();
        end
    end

endmodule

FILE: bench/cooling_mode_controller_tb.sv
// Stimulus and verdict for the cooling mode controller bench.
module cooling_mode_controller_tb;
    import cmc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]             CMD_NONE    = 2'd0;
    localparam logic [1:0]             CMD_UNUSED  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED  = 3'd7;
    localparam int                     IDLE_PCT    = 9;
    localparam int                     STALL_LIMIT = 2000;
    localparam int                     DRAIN_WAIT  = 8;
    localparam int                     TEMP_FLOOR  = -400;
    localparam int                     TEMP_CEIL   = 1250;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     button_level;
    logic [1:0]               command;
    logic                     sample_strobe;
    logic                     sample_ok;
    logic signed [TEMP_W-1:0] sample_temp;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               mode;
    logic                     green_led;
    logic                     red_led;
    logic                     sensor_fault;
    logic signed [TEMP_W-1:0] held_temp;
    logic [2:0]               cause;
    logic                     cfg_write;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    int                       fail_count;
    int                       pending_count;
    int                       checked_count;
    logic [7:0]               causes_seen;

    int                       ticks_sent = 0;
    int                       idle_cycles = 0;
    int                       phases_run = 0;
    logic                     quiet = 1'b0;
    int                       cfg_hi = 250;
    int                       cfg_lo = 200;
    int                       cfg_long = 1000;
    int                       cfg_deb = 50;

    cooling_mode_controller i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .button_level (button_level),
        .command      (command),
        .sample_strobe(sample_strobe),
        .sample_ok    (sample_ok),
        .sample_temp  (sample_temp),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mode         (mode),
        .green_led    (green_led),
        .red_led      (red_led),
        .sensor_fault (sensor_fault),
        .held_temp    (held_temp),
        .cause        (cause),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    cmc_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .button_level (button_level),
        .command      (command),
        .sample_strobe(sample_strobe),
        .sample_ok    (sample_ok),
        .sample_temp  (sample_temp),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mode         (mode),
        .green_led    (green_led),
        .red_led      (red_led),
        .sensor_fault (sensor_fault),
        .held_temp    (held_temp),
        .cause        (cause),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending_count(pending_count),
        .checked_count(checked_count),
        .causes_seen  (causes_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // one input beat, held until accepted; returns just after a falling edge
    task automatic send_tick(input logic lvl, input logic [1:0] cmd, input logic strobe,
                             input logic ok, input int temp);
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        button_level <= lvl;
        command <= cmd;
        sample_strobe <= strobe;
        sample_ok <= ok;
        sample_temp <= TEMP_W'(temp);
        do
            @(posedge clk);
        while (in_stall);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
    endtask

    task automatic set_config(input int hi, input int lo, input int lp, input int db,
                              input int bh);
        drain();
        put_reg(REG_SETPOINT_HIGH, CFG_DATA_W'(hi));
        put_reg(REG_SETPOINT_LOW, CFG_DATA_W'(lo));
        put_reg(REG_LONG_PRESS, CFG_DATA_W'(lp));
        put_reg(REG_DEBOUNCE, CFG_DATA_W'(db));
        put_reg(REG_BLINK_HALF, CFG_DATA_W'(bh));
        put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_write <= 1'b0;
        cfg_hi = hi;
        cfg_lo = lo;
        cfg_long = lp;
        cfg_deb = db;
        phases_run++;
    endtask

    function automatic int pick_temp();
        int k;
        int t;
        k = $urandom_range(0, 9);
        if (k < 4)
            t = cfg_hi + int'($urandom_range(0, 6)) - 3;
        else if (k < 8)
            t = cfg_lo + int'($urandom_range(0, 6)) - 3;
        else
            t = int'($urandom_range(0, TEMP_CEIL - TEMP_FLOOR)) + TEMP_FLOOR;
        if (t < TEMP_FLOOR)
            t = TEMP_FLOOR;
        if (t > TEMP_CEIL)
            t = TEMP_CEIL;
        return t;
    endfunction

    task automatic random_tick(input logic lvl);
        int         r;
        logic [1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 2)
            cmd = CMD_ERROR;
        else if (r < 7)
            cmd = CMD_RESET;
        else if (r < 8)
            cmd = CMD_UNUSED;
        else
            cmd = CMD_NONE;
        send_tick(lvl, cmd, $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 95,
                  pick_temp());
    endtask

    // press lengths cluster round the bounce and long-press thresholds
    task automatic random_press();
        int k;
        int len;
        k = $urandom_range(0, 9);
        if (k < 3)
            len = cfg_deb + int'($urandom_range(0, 4)) - 2;
        else if (k < 6)
            len = cfg_long + int'($urandom_range(0, 4)) - 2;
        else if (k < 8)
            len = $urandom_range(1, 60);
        else
            len = $urandom_range(1, 2);
        if (len < 1)
            len = 1;
        if (len > 80)
            len = 80;
        repeat (len)
            random_tick(1'b0);
        repeat ($urandom_range(1, 12))
            random_tick(1'b1);
    endtask

    task automatic run_phase(input int n);
        int goal;
        goal = ticks_sent + n;
        while (ticks_sent < goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    random_tick(1'($urandom_range(0, 1)));
            end
            else
            begin
                random_press();
            end
        end
    endtask

    initial
    begin : stimulus
        int hi;
        int lo;
        int lp;
        rst_n = 1'b0;
        in_valid = 1'b0;
        button_level = 1'b1;
        command = CMD_NONE;
        sample_strobe = 1'b0;
        sample_ok = 1'b0;
        sample_temp = '0;
        cfg_write = 1'b0;
        cfg_index = REG_SETPOINT_HIGH;
        cfg_data = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults: hysteresis edges, commands, faults
        send_tick(1'b1, CMD_NONE, 1'b0, 1'b0, 0);
        send_tick(1'b1, CMD_NONE, 1'b1, 1'b1, TEMP_CEIL);
        send_tick(1'b1, CMD_NONE, 1'b1, 1'b1, TEMP_FLOOR);
        send_tick(1'b1, CMD_NONE, 1'b1, 1'b1, 250);
        send_tick(1'b1, CMD_NONE, 1'b1, 1'b1, 200);
        send_tick(1'b1, CMD_UNUSED, 1'b0, 1'b1, 0);
        send_tick(1'b1, CMD_ERROR, 1'b0, 1'b1, 0);
        send_tick(1'b1, CMD_ERROR, 1'b1, 1'b1, 300);
        send_tick(1'b1, CMD_NONE, 1'b1, 1'b0, 0);
        send_tick(1'b1, CMD_RESET, 1'b0, 1'b1, 0);
        send_tick(1'b1, CMD_RESET, 1'b1, 1'b0, -1);
        send_tick(1'b1, CMD_RESET, 1'b0, 1'b1, 0);

        // presses: bounce, short, long, and one while in error
        set_config(250, 200, 6, 2, 2);
        send_tick(1'b0, CMD_NONE, 1'b0, 1'b1, 0);
        send_tick(1'b1, CMD_NONE, 1'b0, 1'b1, 0);
        repeat (3)
            send_tick(1'b0, CMD_NONE, 1'b0, 1'b1, 0);
        repeat (2)
            send_tick(1'b1, CMD_NONE, 1'b0, 1'b1, 0);
        repeat (6)
            send_tick(1'b0, CMD_NONE, 1'b0, 1'b1, 0);
        send_tick(1'b1, CMD_ERROR, 1'b0, 1'b1, 0);
        repeat (3)
            send_tick(1'b0, CMD_NONE, 1'b0, 1'b1, 0);
        send_tick(1'b1, CMD_NONE, 1'b0, 1'b1, 0);
        send_tick(1'b1, CMD_RESET, 1'b0, 1'b1, 0);

        set_config(250, 200, 8, 3, 4);
        run_phase(200);

        quiet = 1'b1;
        set_config(TEMP_CEIL, TEMP_FLOOR, 1, 0, 1);
        run_phase(150);
        quiet = 1'b0;

        // swapped setpoints, nothing short of a long press counts
        set_config(100, 300, 12, 65535, 65535);
        run_phase(150);

        // hold the button well past the long-press time
        set_config(TEMP_FLOOR, TEMP_CEIL, 120, 0, 2);
        repeat (150)
            send_tick(1'b0, CMD_NONE, 1'b0, 1'b1, 0);
        send_tick(1'b1, CMD_NONE, 1'b0, 1'b1, 0);
        run_phase(120);

        repeat (3)
        begin
            hi = int'($urandom_range(0, TEMP_CEIL - TEMP_FLOOR)) + TEMP_FLOOR;
            lo = hi - int'($urandom_range(0, 150));
            if (lo < TEMP_FLOOR)
                lo = TEMP_FLOOR;
            lp = $urandom_range(1, 40);
            set_config(hi, lo, lp, $urandom_range(0, lp + 3), $urandom_range(1, 20));
            run_phase(150);
        end

        drain();
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("%0d ticks over %0d configuration phases, %0d results checked",
                 ticks_sent, phases_run, checked_count);
        $display("transition causes seen (bit per cause): %b", causes_seen);
        if (fail_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: cooling_mode_controller.f
sv/cmc_pkg.sv
sv/cooling_mode_controller.sv
bench/cmc_checker.sv
bench/cooling_mode_controller_tb.sv
